>>> sv/tbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

    localparam int ADDR_W             = 32;
    localparam int LOCAL_HIST_ENTRIES = 1024;
    localparam int LOCAL_HIST_BITS    = 11;
    localparam int GLOBAL_HIST_BITS   = 12;

    localparam int LH_IDX_W   = $clog2(LOCAL_HIST_ENTRIES);
    localparam int PC_W       = GLOBAL_HIST_BITS - 2;
    localparam int LCNT_DEPTH = 1 << LOCAL_HIST_BITS;
    localparam int GCNT_DEPTH = 1 << GLOBAL_HIST_BITS;

    localparam int LCNT_W = 3;
    localparam int GCNT_W = 2;

    localparam logic [LCNT_W-1:0] LCNT_MAX        = 3'd7;
    localparam logic [LCNT_W-1:0] LCNT_THRESH     = 3'd3;
    localparam logic [GCNT_W-1:0] GCNT_MAX        = 2'd3;
    localparam logic [GCNT_W-1:0] GCNT_THRESH     = 2'd1;
    localparam logic [GCNT_W-1:0] CHOOSE_GLOBAL   = 2'd2;

    // clearing pass covers the deepest table
    localparam int CLR_DEPTH_A = (LCNT_DEPTH > LOCAL_HIST_ENTRIES) ? LCNT_DEPTH
                                                                    : LOCAL_HIST_ENTRIES;
    localparam int CLR_DEPTH   = (GCNT_DEPTH > CLR_DEPTH_A) ? GCNT_DEPTH : CLR_DEPTH_A;
    localparam int CLR_W       = $clog2(CLR_DEPTH);

    localparam int FQ_DEPTH = 2;
    localparam int RQ_DEPTH = 2;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                op;
        logic                cond;
        logic                taken;
        logic [LH_IDX_W-1:0] hidx;
        logic [PC_W-1:0]     pcbits;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_front_head;

    typedef struct packed {
        logic take;
        logic clearing;
    } t_back_req;

    typedef struct packed {
        logic pred;
        logic chose;
    } t_result;

endpackage

`default_nettype wire

>>> sv/tbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/tbp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tbp_front
    import tbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              i_op,
    input  wire logic [ADDR_W-1:0] i_branch_address,
    input  wire logic              i_is_conditional,
    input  wire logic              i_taken,
    input  wire t_back_req         i_req,
    output t_front_head            o_head
);

    localparam int PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(FQ_DEPTH + 1);

    t_item            r_q [FQ_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_item            w_item;
    logic             w_wr;
    logic             w_rd;

    // pull out the index bits once, on the way in
    always_comb begin
        w_item.op     = i_op;
        w_item.cond   = i_is_conditional;
        w_item.taken  = i_taken;
        w_item.hidx   = i_branch_address[2 +: LH_IDX_W];
        w_item.pcbits = i_branch_address[GLOBAL_HIST_BITS-1:2];
    end

    assign full = (r_cnt == CNT_W'(FQ_DEPTH)) | i_req.clearing;
    assign w_wr = push & ~full;
    assign w_rd = i_req.take;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PTR_W'(FQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd) begin
            n_rp = (r_rp == PTR_W'(FQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_item;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];

endmodule

`default_nettype wire

>>> sv/tbp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tbp_back
    import tbp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_front_head i_head,
    output t_back_req        o_req,
    input  wire logic        pop,
    output logic             empty,
    output logic             o_predicted_taken,
    output logic             o_chose_global
);

    localparam int RQ_PTR_W = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    t_state                      r_state, n_state;
    logic [CLR_W-1:0]            r_clr_addr;
    logic [GLOBAL_HIST_BITS-1:0] r_path_hist, n_path_hist;
    t_item                       r_item;
    logic [GLOBAL_HIST_BITS-1:0] r_gidx;

    t_result                     r_rq [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]         r_rq_wp, r_rq_rp;
    logic [RQ_CNT_W-1:0]         r_rq_cnt;
    logic                        rq_full;
    logic                        rq_pop;

    logic                        take;
    logic                        rd_cnt;
    logic                        fire;
    logic                        clearing;
    logic                        train;

    logic [GLOBAL_HIST_BITS-1:0] w_gidx;
    logic [LOCAL_HIST_BITS-1:0]  lh_rdata;
    logic [LCNT_W-1:0]           lc_rdata;
    logic [GCNT_W-1:0]           gc_rdata;
    logic [GCNT_W-1:0]           ch_rdata;

    logic                        lpred, gpred, use_g;
    t_result                     w_res;
    logic [LOCAL_HIST_BITS-1:0]  lh_next;
    logic [LCNT_W-1:0]           lc_next;
    logic [GCNT_W-1:0]           gc_next;
    logic [GCNT_W-1:0]           ch_next;

    logic                        tbl_we;
    logic [LH_IDX_W-1:0]         lh_waddr;
    logic [LOCAL_HIST_BITS-1:0]  lc_waddr;
    logic [GLOBAL_HIST_BITS-1:0] g_waddr;
    logic [LOCAL_HIST_BITS-1:0]  lh_wdata;
    logic [LCNT_W-1:0]           lc_wdata;
    logic [GCNT_W-1:0]           gc_wdata;
    logic [GCNT_W-1:0]           ch_wdata;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CLR_W'(CLR_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_head.valid) n_state = ST_HIST;
            end
            ST_HIST: n_state = ST_EXEC;
            ST_EXEC: begin
                if (!rq_full) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb begin
        take     = 1'b0;
        rd_cnt   = 1'b0;
        fire     = 1'b0;
        clearing = 1'b0;
        unique case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_IDLE:  take     = i_head.valid;
            ST_HIST:  rd_cnt   = 1'b1;
            ST_EXEC:  fire     = ~rq_full;
            default:  clearing = 1'b1;
        endcase
    end

    assign o_req.take     = take;
    assign o_req.clearing = clearing;

    assign w_gidx = r_path_hist ^ GLOBAL_HIST_BITS'(i_head.item.pcbits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_path_hist <= '0;
        end else begin
            r_state     <= n_state;
            r_path_hist <= n_path_hist;
            if (clearing) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_head.item;
            r_gidx <= w_gidx;
        end
    end

    // prediction and training from the words read out
    always_comb begin
        lpred = lc_rdata > LCNT_THRESH;
        gpred = gc_rdata > GCNT_THRESH;
        use_g = ch_rdata >= CHOOSE_GLOBAL;

        w_res.pred  = r_item.cond ? (use_g ? gpred : lpred) : 1'b1;
        w_res.chose = r_item.cond & use_g;

        ch_next = ch_rdata;
        if (gpred == r_item.taken && lpred != r_item.taken) begin
            if (ch_rdata != GCNT_MAX) ch_next = ch_rdata + 1'b1;
        end else if (gpred != r_item.taken && lpred == r_item.taken) begin
            if (ch_rdata != '0) ch_next = ch_rdata - 1'b1;
        end

        gc_next = gc_rdata;
        lc_next = lc_rdata;
        if (r_item.taken) begin
            if (gc_rdata != GCNT_MAX) gc_next = gc_rdata + 1'b1;
            if (lc_rdata != LCNT_MAX) lc_next = lc_rdata + 1'b1;
        end else begin
            if (gc_rdata != '0) gc_next = gc_rdata - 1'b1;
            if (lc_rdata != '0) lc_next = lc_rdata - 1'b1;
        end

        lh_next = {lh_rdata[LOCAL_HIST_BITS-2:0], r_item.taken};

        train = fire & (r_item.op == OP_UPDATE) & r_item.cond;

        n_path_hist = r_path_hist;
        if (fire && r_item.op == OP_UPDATE) begin
            n_path_hist = {r_path_hist[GLOBAL_HIST_BITS-2:0], r_item.taken};
        end
    end

    // table write port: zero sweep after reset, training otherwise
    always_comb begin
        tbl_we = clearing | train;
        if (clearing) begin
            lh_waddr = r_clr_addr[LH_IDX_W-1:0];
            lc_waddr = r_clr_addr[LOCAL_HIST_BITS-1:0];
            g_waddr  = r_clr_addr[GLOBAL_HIST_BITS-1:0];
            lh_wdata = '0;
            lc_wdata = '0;
            gc_wdata = '0;
            ch_wdata = '0;
        end else begin
            lh_waddr = r_item.hidx;
            lc_waddr = lh_rdata;
            g_waddr  = r_gidx;
            lh_wdata = lh_next;
            lc_wdata = lc_next;
            gc_wdata = gc_next;
            ch_wdata = ch_next;
        end
    end

    tbp_ram #(
        .WIDTH (LOCAL_HIST_BITS),
        .DEPTH (LOCAL_HIST_ENTRIES)
    ) u_local_hist (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (lh_waddr),
        .i_wdata (lh_wdata),
        .i_re    (take),
        .i_raddr (i_head.item.hidx),
        .o_rdata (lh_rdata)
    );

    // indexed by the history word, so read in the state after the history read
    tbp_ram #(
        .WIDTH (LCNT_W),
        .DEPTH (LCNT_DEPTH)
    ) u_local_cnt (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (lc_waddr),
        .i_wdata (lc_wdata),
        .i_re    (rd_cnt),
        .i_raddr (lh_rdata),
        .o_rdata (lc_rdata)
    );

    tbp_ram #(
        .WIDTH (GCNT_W),
        .DEPTH (GCNT_DEPTH)
    ) u_global_cnt (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (g_waddr),
        .i_wdata (gc_wdata),
        .i_re    (take),
        .i_raddr (w_gidx),
        .o_rdata (gc_rdata)
    );

    tbp_ram #(
        .WIDTH (GCNT_W),
        .DEPTH (GCNT_DEPTH)
    ) u_chooser (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (g_waddr),
        .i_wdata (ch_wdata),
        .i_re    (take),
        .i_raddr (w_gidx),
        .o_rdata (ch_rdata)
    );

    // result queue
    assign rq_full = (r_rq_cnt == RQ_CNT_W'(RQ_DEPTH));
    assign empty   = (r_rq_cnt == '0);
    assign rq_pop  = pop & ~empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wp  <= '0;
            r_rq_rp  <= '0;
            r_rq_cnt <= '0;
        end else begin
            if (fire) begin
                r_rq_wp <= (r_rq_wp == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : r_rq_wp + 1'b1;
            end
            if (rq_pop) begin
                r_rq_rp <= (r_rq_rp == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : r_rq_rp + 1'b1;
            end
            if (fire && !rq_pop) begin
                r_rq_cnt <= r_rq_cnt + 1'b1;
            end else if (rq_pop && !fire) begin
                r_rq_cnt <= r_rq_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rq[r_rq_wp] <= w_res;
        end
    end

    assign o_predicted_taken = r_rq[r_rq_rp].pred;
    assign o_chose_global    = r_rq[r_rq_rp].chose;

endmodule

`default_nettype wire

>>> sv/tournament_branch_predictor.sv
`timescale 1ns / 1ps
`default_nettype none

// Tournament branch predictor: per-address local history with 3-bit counters,
// a gshare global side with 2-bit counters, and a 2-bit chooser. Every word
// gets exactly one result word, the prediction from the tables as they stood
// before it; conditional update words then train the tables and every update
// word shifts the path history. Words enter a two-entry input queue and results
// leave through a two-entry output queue, so both sides can stall freely. The
// back-end sequencer reads local history, chooser and global counter, then the
// local counter that the history word selects, then forms the result and writes
// back, waiting while the output queue is full. After reset a clearing pass
// zeroes all tables, one entry a cycle, with full held high until it ends.
module tournament_branch_predictor
    import tbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              i_op,
    input  wire logic [ADDR_W-1:0] i_branch_address,
    input  wire logic              i_is_conditional,
    input  wire logic              i_taken,
    output logic                   empty,
    input  wire logic              pop,
    output logic                   o_predicted_taken,
    output logic                   o_chose_global
);

    t_front_head head;
    t_back_req   req;

    tbp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_op             (i_op),
        .i_branch_address (i_branch_address),
        .i_is_conditional (i_is_conditional),
        .i_taken          (i_taken),
        .i_req            (req),
        .o_head           (head)
    );

    tbp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .o_req             (req),
        .pop               (pop),
        .empty             (empty),
        .o_predicted_taken (o_predicted_taken),
        .o_chose_global    (o_chose_global)
    );

    a_take_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.take |-> head.valid)
        else $error("sequencer took a word from an empty input queue");

    a_no_take_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.clearing |-> (full && !req.take))
        else $error("input side open during table clearing");

    a_take_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.take |=> !req.take)
        else $error("sequencer took words on consecutive cycles");

endmodule

`default_nettype wire

>>> test/prediction_checker.sv
`timescale 1ns / 1ps

module prediction_checker
    import tbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic              i_full,
    input  wire logic              i_op,
    input  wire logic [ADDR_W-1:0] i_branch_address,
    input  wire logic              i_is_conditional,
    input  wire logic              i_taken,
    input  wire logic              i_empty,
    input  wire logic              i_pop,
    input  wire logic              i_predicted_taken,
    input  wire logic              i_chose_global,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_global_picks
);

    logic [LOCAL_HIST_BITS-1:0]  local_hist  [LOCAL_HIST_ENTRIES];
    logic [LCNT_W-1:0]           local_ctr   [LCNT_DEPTH];
    logic [GCNT_W-1:0]           global_ctr  [GCNT_DEPTH];
    logic [GCNT_W-1:0]           chooser_ctr [GCNT_DEPTH];
    logic [GLOBAL_HIST_BITS-1:0] path_hist;

    t_result pending_predictions[$];
    t_result want;
    t_result got;
    int      errors       = 0;
    int      checked      = 0;
    int      global_picks = 0;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // prediction from the tables as they stand, then training for update words
    task automatic predict_and_train(
        input  logic              w_op,
        input  logic [ADDR_W-1:0] w_addr,
        input  logic              w_cond,
        input  logic              w_tk,
        output t_result           res
    );
        logic [LH_IDX_W-1:0]         hidx;
        logic [PC_W-1:0]             pcbits;
        logic [GLOBAL_HIST_BITS-1:0] gidx;
        logic [LOCAL_HIST_BITS-1:0]  lidx;
        logic                        lp;
        logic                        gp;
        logic                        use_g;
        hidx   = w_addr[LH_IDX_W+1:2];
        pcbits = w_addr[GLOBAL_HIST_BITS-1:2];
        gidx   = path_hist ^ GLOBAL_HIST_BITS'(pcbits);
        lidx   = local_hist[hidx];
        lp     = local_ctr[lidx] > LCNT_THRESH;
        gp     = global_ctr[gidx] > GCNT_THRESH;
        use_g  = chooser_ctr[gidx] >= CHOOSE_GLOBAL;
        res.pred  = w_cond ? (use_g ? gp : lp) : 1'b1;
        res.chose = w_cond & use_g;
        if (w_op == OP_UPDATE) begin
            if (w_cond) begin
                // chooser only moves when exactly one side was right
                if (gp == w_tk && lp != w_tk) begin
                    if (chooser_ctr[gidx] != GCNT_MAX)
                        chooser_ctr[gidx] = chooser_ctr[gidx] + 1'b1;
                end else if (gp != w_tk && lp == w_tk) begin
                    if (chooser_ctr[gidx] != '0)
                        chooser_ctr[gidx] = chooser_ctr[gidx] - 1'b1;
                end
                if (w_tk) begin
                    if (global_ctr[gidx] != GCNT_MAX)
                        global_ctr[gidx] = global_ctr[gidx] + 1'b1;
                    if (local_ctr[lidx] != LCNT_MAX)
                        local_ctr[lidx] = local_ctr[lidx] + 1'b1;
                end else begin
                    if (global_ctr[gidx] != '0)
                        global_ctr[gidx] = global_ctr[gidx] - 1'b1;
                    if (local_ctr[lidx] != '0)
                        local_ctr[lidx] = local_ctr[lidx] - 1'b1;
                end
                local_hist[hidx] = {local_hist[hidx][LOCAL_HIST_BITS-2:0], w_tk};
            end
            path_hist = {path_hist[GLOBAL_HIST_BITS-2:0], w_tk};
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (local_hist[k])  local_hist[k]  = '0;
            foreach (local_ctr[k])   local_ctr[k]   = '0;
            foreach (global_ctr[k])  global_ctr[k]  = '0;
            foreach (chooser_ctr[k]) chooser_ctr[k] = '0;
            path_hist = '0;
            pending_predictions.delete();
        end else begin
            if (i_pop && !i_empty) begin
                got.pred  = i_predicted_taken;
                got.chose = i_chose_global;
                if (pending_predictions.size() == 0) begin
                    report($sformatf("result word with nothing expected (taken %0b global %0b)",
                                     got.pred, got.chose));
                end else begin
                    want = pending_predictions.pop_front();
                    checked++;
                    if (got.pred !== want.pred)
                        report($sformatf("result %0d predicted_taken %0b, expected %0b",
                                         checked, got.pred, want.pred));
                    if (got.chose !== want.chose)
                        report($sformatf("result %0d chose_global %0b, expected %0b",
                                         checked, got.chose, want.chose));
                end
            end
            if (i_push && !i_full) begin
                predict_and_train(i_op, i_branch_address, i_is_conditional, i_taken, want);
                pending_predictions.push_back(want);
                if (want.chose)
                    global_picks++;
            end
        end
        o_errors       <= errors;
        o_pending      <= pending_predictions.size();
        o_checked      <= checked;
        o_global_picks <= global_picks;
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import tbp_pkg::*;

    localparam int RANDOM_WORDS = 1600;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              push  = 1'b0;
    logic              pop   = 1'b0;
    logic              op    = OP_PREDICT;
    logic [ADDR_W-1:0] addr  = '0;
    logic              cond  = 1'b0;
    logic              tk    = 1'b0;
    logic              full;
    logic              empty;
    logic              pred;
    logic              chose;

    int errors;
    int pending;
    int checked;
    int global_picks;
    int n_sent = 0;
    int n_upd  = 0;
    int n_cond = 0;
    bit calm   = 1'b0;

    logic [ADDR_W-1:0] hot_addr [16];

    tournament_branch_predictor dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .push              (push),
        .full              (full),
        .i_op              (op),
        .i_branch_address  (addr),
        .i_is_conditional  (cond),
        .i_taken           (tk),
        .empty             (empty),
        .pop               (pop),
        .o_predicted_taken (pred),
        .o_chose_global    (chose)
    );

    prediction_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_push            (push),
        .i_full            (full),
        .i_op              (op),
        .i_branch_address  (addr),
        .i_is_conditional  (cond),
        .i_taken           (tk),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_predicted_taken (pred),
        .i_chose_global    (chose),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_global_picks    (global_picks)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    // mostly back to back or short, now and then a long pause
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(
        input logic              w_op,
        input logic [ADDR_W-1:0] w_addr,
        input logic              w_cond,
        input logic              w_tk
    );
        int idle;
        idle = gap_len();
        if (idle > 0) begin
            push = 1'b0;
            repeat (idle) @(negedge clk);
        end
        push = 1'b1;
        op   = w_op;
        addr = w_addr;
        cond = w_cond;
        tk   = w_tk;
        @(posedge clk);
        while (full) @(posedge clk);
        n_sent++;
        if (w_op == OP_UPDATE)
            n_upd++;
        if (w_cond)
            n_cond++;
        @(negedge clk);
    endtask

    // one branch resolved many times with a fixed outcome pattern, so histories fill
    // and counters reach saturation
    task automatic train_branch();
        logic [ADDR_W-1:0] a;
        int                kind;
        int                len;
        logic [2:0]        motif;
        logic              outcome;
        a     = hot_addr[$urandom_range(0, 15)];
        kind  = $urandom_range(0, 4);
        len   = $urandom_range(8, 40);
        motif = 3'($urandom);
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: outcome = 1'b1;
                1: outcome = 1'b0;
                2: outcome = i[0];
                3: outcome = motif[i % 3];
                default: outcome = ($urandom_range(0, 9) < 8);
            endcase
            if ($urandom_range(0, 3) == 0)
                send_word(OP_PREDICT, a, 1'b1, 1'($urandom_range(0, 1)));
            send_word(OP_UPDATE, a, 1'b1, outcome);
            if ($urandom_range(0, 9) == 0)
                send_word($urandom_range(0, 1) ? OP_UPDATE : OP_PREDICT,
                          hot_addr[$urandom_range(0, 15)], 1'b0,
                          1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : result_side
        int stall;
        pop = 1'b0;
        wait (rst_n);
        forever begin
            stall = gap_len();
            if (stall > 0) begin
                pop = 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop = 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int target;
        int k;
        for (int i = 0; i < 16; i++)
            hot_addr[i] = $urandom;
        // upper halves alias the lower halves on bits 11:2
        for (int i = 8; i < 16; i++)
            hot_addr[i] = {20'($urandom), hot_addr[i-8][11:2], 2'($urandom)};

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(OP_PREDICT, 32'h0000_0000, 1'b1, 1'b0);
        send_word(OP_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // jumps only move the path history
        send_word(OP_UPDATE,  32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(OP_UPDATE,  32'h0000_0003, 1'b0, 1'b0);
        send_word(OP_UPDATE,  32'hFFFF_FFFC, 1'b1, 1'b1);
        send_word(OP_UPDATE,  32'hFFFF_FFFC, 1'b1, 1'b0);
        send_word(OP_PREDICT, 32'hFFFF_FFFC, 1'b1, 1'b1);
        send_word(OP_PREDICT, 32'h8000_0000, 1'b1, 1'b1);
        send_word(OP_UPDATE,  32'h1234_5678, 1'b1, 1'b0);
        send_word(OP_UPDATE,  32'hEDCB_A678, 1'b1, 1'b1);
        send_word(OP_PREDICT, 32'h0000_0678, 1'b1, 1'b0);
        repeat (12) send_word(OP_UPDATE, 32'h0000_0100, 1'b1, 1'b1);
        send_word(OP_PREDICT, 32'h0000_0100, 1'b1, 1'b0);

        target = n_sent + RANDOM_WORDS;
        while (n_sent < target) begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0) begin
                train_branch();
            end else begin
                repeat ($urandom_range(1, 8))
                    send_word($urandom_range(0, 1) ? OP_UPDATE : OP_PREDICT, $urandom,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        push = 1'b0;

        calm = 1'b1;
        for (k = 0; k < 2000 && pending != 0; k++)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);

        $display("covered %0d words: %0d updates, %0d conditional, %0d results checked",
                 n_sent, n_upd, n_cond, checked);
        $display("chooser picked the global side for %0d conditional predictions",
                 global_picks);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/tbp_pkg.sv
sv/tbp_ram.sv
sv/tbp_front.sv
sv/tbp_back.sv
sv/tournament_branch_predictor.sv
test/prediction_checker.sv
test/tb.sv
